// File: hw/rtl/hkma_pkg.sv
`timescale 1ns / 1ps
package hkma_pkg;

   localparam int ENTRIES = 256;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int RIDX_W  = 8;
   localparam int CMP_W   = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;
   localparam int KEY_W   = 31;
   localparam int AMP_W   = 16;
   localparam int OUT_CNT_W = 9;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_MERGE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // chain word: one cell per cycle while the chain advances
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [KEY_W-1:0]  key;
      logic [AMP_W-1:0]  amp;
      logic [RIDX_W-1:0] idx;
      logic [CNT_W-1:0]  match_cnt;
      logic [CNT_W-1:0]  total;
      logic              appended;
      logic              rd_valid;
      logic [KEY_W-1:0]  rd_key;
      logic [AMP_W-1:0]  rd_amp;
   } token_type;

endpackage

// File: hw/rtl/hkma_req_if.sv
`timescale 1ns / 1ps
interface hkma_req_if import hkma_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [1:0]  layer;
   logic [4:0]  ladder;
   logic [3:0]  sensor;
   logic [1:0]  sensor_section;
   logic [1:0]  sensor_readout;
   logic [15:0] channel;
   logic [AMP_W-1:0]  amplitude;
   logic [RIDX_W-1:0] entry_index;

   modport source (
      output valid, opcode, layer, ladder, sensor, sensor_section, sensor_readout,
             channel, amplitude, entry_index,
      input  ready
   );
   modport sink (
      input  valid, opcode, layer, ladder, sensor, sensor_section, sensor_readout,
             channel, amplitude, entry_index,
      output ready
   );
endinterface

// File: hw/rtl/hkma_rsp_if.sv
`timescale 1ns / 1ps
interface hkma_rsp_if import hkma_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [OUT_CNT_W-1:0] match_count;
   logic                 appended;
   logic                 table_full;
   logic [OUT_CNT_W-1:0] entry_total;
   logic [1:0]           read_layer;
   logic [4:0]           read_ladder;
   logic [3:0]           read_sensor;
   logic [1:0]           read_section;
   logic [1:0]           read_readout;
   logic [15:0]          read_channel;
   logic [AMP_W-1:0]     read_amplitude;
   logic                 read_valid;

   modport source (
      output valid, match_count, appended, table_full, entry_total, read_layer,
             read_ladder, read_sensor, read_section, read_readout, read_channel,
             read_amplitude, read_valid,
      input  ready
   );
   modport sink (
      input  valid, match_count, appended, table_full, entry_total, read_layer,
             read_ladder, read_sensor, read_section, read_readout, read_channel,
             read_amplitude, read_valid,
      output ready
   );
endinterface

// File: hw/rtl/hkma_cell.sv
`timescale 1ns / 1ps
module hkma_cell import hkma_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [IDX_W-1:0] cell_idx,
   input  token_type        tok_in,
   output token_type        tok_out
);

   logic             used_ff,  used_in;
   logic             orig_ff,  orig_in;
   logic [KEY_W-1:0] key_ff,   key_in;
   logic [AMP_W-1:0] amp_ff,   amp_in;
   token_type        tok_ff,   tok_nx_in;

   logic             live;
   logic             hit;
   logic             take;
   logic [AMP_W:0]   sum;

   always_comb begin
      live = tok_in.valid && advance;
      sum  = {1'b0, amp_ff} + {1'b0, tok_in.amp};
      hit  = used_ff && orig_ff && (tok_in.op == OP_MERGE) && (key_ff == tok_in.key);
      // first free cell: all occupied cells lie before it
      take = !used_ff && !tok_in.appended &&
             ((tok_in.op == OP_LOAD) ||
              ((tok_in.op == OP_MERGE) && (tok_in.match_cnt == '0)));

      used_in   = used_ff;
      orig_in   = orig_ff;
      key_in    = key_ff;
      amp_in    = amp_ff;
      tok_nx_in = tok_in;

      if (tok_in.valid) begin
         if (tok_in.op == OP_CLEAR) begin
            used_in = 1'b0;
         end else begin
            if (used_ff) begin
               tok_nx_in.total = tok_in.total + CNT_W'(1);
            end
            if (hit) begin
               amp_in = sum[AMP_W] ? {AMP_W{1'b1}} : sum[AMP_W-1:0];
               tok_nx_in.match_cnt = tok_in.match_cnt + CNT_W'(1);
            end
            if (take) begin
               used_in  = 1'b1;
               orig_in  = (tok_in.op == OP_LOAD);
               key_in   = tok_in.key;
               amp_in   = tok_in.amp;
               tok_nx_in.appended = 1'b1;
               tok_nx_in.total    = tok_in.total + CNT_W'(1);
            end
            if ((tok_in.op == OP_READ) && used_ff &&
                (CMP_W'(tok_in.idx) == CMP_W'(cell_idx))) begin
               tok_nx_in.rd_valid = 1'b1;
               tok_nx_in.rd_key   = key_ff;
               tok_nx_in.rd_amp   = amp_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (live) begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (live) begin
         orig_ff <= orig_in;
         key_ff  <= key_in;
         amp_ff  <= amp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_nx_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: hw/rtl/hit_key_match_accumulate.sv
`timescale 1ns / 1ps
// path: an accepted req word is registered in each cell in turn, then leaves as rsp
// throughput: one word per cycle while rsp is taken; the whole cell chain
//   advances together and halts while a finished rsp word waits
// reset: synchronous; empties the table (all occupancy bits cleared) and
//   drops every word in flight; entry contents are left as they are
module hit_key_match_accumulate import hkma_pkg::*; (
   input logic       clock,
   input logic       reset,
   hkma_req_if.sink  req_chan,
   hkma_rsp_if.source rsp_chan
);

   // tok[j] feeds cell j, tok[ENTRIES] is the result register
   token_type tok [ENTRIES+1];
   logic      advance;
   token_type last;

   // the chain moves when the result slot is empty or being taken
   assign advance        = !tok[ENTRIES].valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // new word enters cell 0 straight from the request port
   always_comb begin
      tok[0]          = '0;
      tok[0].valid    = req_chan.valid;
      tok[0].op       = op_type'(req_chan.opcode);
      tok[0].key      = {req_chan.layer, req_chan.ladder, req_chan.sensor,
                         req_chan.sensor_section, req_chan.sensor_readout,
                         req_chan.channel};
      tok[0].amp      = req_chan.amplitude;
      tok[0].idx      = req_chan.entry_index;
   end

   // row of table cells; occupancy is a thermometer, filled from cell 0 up
   for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
      hkma_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (IDX_W'(j)),
         .tok_in   (tok[j]),
         .tok_out  (tok[j+1])
      );
   end

   assign last = tok[ENTRIES];

   // result word: flags, counts and the read-back entry
   assign rsp_chan.valid       = last.valid;
   assign rsp_chan.match_count = (last.op == OP_MERGE) ? OUT_CNT_W'(last.match_cnt)
                                                       : '0;
   assign rsp_chan.appended    = last.appended;
   // an append that never found a free cell was dropped
   assign rsp_chan.table_full  = !last.appended &&
                                 ((last.op == OP_LOAD) ||
                                  ((last.op == OP_MERGE) && (last.match_cnt == '0)));
   assign rsp_chan.entry_total = OUT_CNT_W'(last.total);

   // read fields stay zero unless a valid entry was captured on the way
   assign rsp_chan.read_valid     = last.rd_valid;
   assign rsp_chan.read_layer     = last.rd_valid ? last.rd_key[30:29] : '0;
   assign rsp_chan.read_ladder    = last.rd_valid ? last.rd_key[28:24] : '0;
   assign rsp_chan.read_sensor    = last.rd_valid ? last.rd_key[23:20] : '0;
   assign rsp_chan.read_section   = last.rd_valid ? last.rd_key[19:18] : '0;
   assign rsp_chan.read_readout   = last.rd_valid ? last.rd_key[17:16] : '0;
   assign rsp_chan.read_channel   = last.rd_valid ? last.rd_key[15:0]  : '0;
   assign rsp_chan.read_amplitude = last.rd_valid ? last.rd_amp        : '0;

endmodule
